// ===== hdl/brg_pkg.sv =====
// Package for the banked ROM and serial ROM port unit.
// Holds the request codes, the memory map constants and the address helpers.
// No dependencies; every other file refers to it by scoped names.
package brg_pkg;

  // Bank size and the auto-increment wrap size. Both are powers of two.
  localparam int BANK_BYTES  = 4096;
  localparam int WRAP_BYTES  = 8192;
  localparam int FIXED_BYTES = 4096;
  localparam int ROM_DEPTH   = FIXED_BYTES + 2 * BANK_BYTES;
  localparam int SROM_DEPTH  = 65536;

  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam int SROM_AW   = $clog2(SROM_DEPTH);
  localparam int BANK_BITS = $clog2(BANK_BYTES);
  localparam int OFF_W     = 13;

  typedef logic [2:0]  req_type_t;
  typedef logic [15:0] addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [OFF_W-1:0] off_t;

  localparam req_type_t REQ_MEM_READ  = 3'd0;
  localparam req_type_t REQ_MEM_WRITE = 3'd1;
  localparam req_type_t REQ_CTRL_BIT  = 3'd2;
  localparam req_type_t REQ_LOAD_ROM  = 3'd3;
  localparam req_type_t REQ_LOAD_SROM = 3'd4;

  localparam off_t PORT_DATA_RD = 13'h1BFC;
  localparam off_t PORT_ADDR_RD = 13'h1BFE;
  localparam off_t PORT_DATA_WR = 13'h1FFC;
  localparam off_t PORT_ADDR_WR = 13'h1FFE;
  localparam off_t FIXED_LIMIT  = off_t'(FIXED_BYTES);
  localparam addr_t BANK_BIT_NUM = 16'h0040;

  localparam addr_t WRAP_MASK = addr_t'(WRAP_BYTES - 1);

  // Serial address after one auto-increment: the low part wraps, the high part stays.
  function automatic addr_t wrap_inc(input addr_t a);
    addr_t sum;
    sum = a + 16'd1;
    return (sum & WRAP_MASK) | (a & ~WRAP_MASK);
  endfunction

endpackage

// ===== hdl/brg_if.sv =====
// Request and response channel interfaces of the banked ROM port unit.
// Depends on brg_pkg for the payload types.
interface brg_req_if (input logic clk);
  logic                valid;
  logic                ready;
  brg_pkg::req_type_t  req_type;
  brg_pkg::addr_t      address;
  brg_pkg::byte_t      write_data;

  modport source (output valid, req_type, address, write_data, input ready);
  modport sink (input valid, req_type, address, write_data, output ready);
endinterface

interface brg_rsp_if (input logic clk);
  logic           valid;
  logic           ready;
  brg_pkg::byte_t read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// ===== hdl/banked_rom_and_grom_port_unit.sv =====
// Top level of the banked ROM and serial ROM port unit.
// Depends on brg_pkg and on the channel interfaces in brg_if.sv.
//
//   channel | dir | payload                          | handshake
//   req     | in  | req_type, address, write_data    | valid / ready
//   rsp     | out | read_data                        | valid / ready
//
// One request is taken per cycle while the read stage is not stalled; its response
// passes through the synchronous ROM or serial ROM read and then the output register.
// The serial address and byte flip-flops change when the request is taken; the
// prefetch byte is refilled from the serial ROM read data when the read stage moves on, in order.
// A stalled response holds the read stage, and then no new request is taken.
// Reset clears the control state only; both memories are undefined until loaded.
// No request is taken while reset is high.
module banked_rom_and_grom_port_unit (
  input logic        clk,
  input logic        rst,
  brg_req_if.sink    req,
  brg_rsp_if.source  rsp
);

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ROM,
    SRC_PREFETCH,
    SRC_BYTE
  } src_t;

  logic [7:0] rom  [brg_pkg::ROM_DEPTH];
  logic [7:0] srom [brg_pkg::SROM_DEPTH];

  // Control state.
  brg_pkg::addr_t serial_address, serial_address_next;
  brg_pkg::byte_t prefetch_byte;
  logic read_low_next, read_low_next_nx;
  logic write_low_next, write_low_next_nx;
  logic high_bank, high_bank_next;

  // Read stage.
  logic           s1_valid;
  src_t           s1_src;
  logic           s1_fetch;
  brg_pkg::byte_t s1_byte;
  brg_pkg::byte_t rom_rdata, srom_rdata;

  // Output register.
  logic           out_valid;
  brg_pkg::byte_t out_data;

  // Request decode.
  logic                        acc;
  logic                        s1_adv;
  brg_pkg::off_t               off;
  logic                        rom_re, srom_re, rom_we, srom_we;
  logic [brg_pkg::ROM_AW-1:0]  rom_raddr;
  logic [brg_pkg::SROM_AW-1:0] srom_raddr;
  src_t                        src;
  logic                        fetch;
  brg_pkg::byte_t              imm_byte;
  brg_pkg::addr_t              fetch_addr;
  brg_pkg::byte_t              s1_result;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !rst && (!s1_valid || s1_adv);
  assign acc       = req.valid && req.ready;
  assign off       = req.address[brg_pkg::OFF_W-1:0];

  always_comb begin
    serial_address_next = serial_address;
    read_low_next_nx    = read_low_next;
    write_low_next_nx   = write_low_next;
    high_bank_next      = high_bank;
    rom_re     = 1'b0;
    srom_re    = 1'b0;
    rom_we     = 1'b0;
    srom_we    = 1'b0;
    rom_raddr  = '0;
    fetch_addr = serial_address;
    src        = SRC_ZERO;
    fetch      = 1'b0;
    imm_byte   = '0;
    if (acc) begin
      unique case (req.req_type)
        brg_pkg::REQ_MEM_READ: begin
          priority if (off < brg_pkg::FIXED_LIMIT) begin
            rom_re    = 1'b1;
            rom_raddr = brg_pkg::ROM_AW'(off);
            src       = SRC_ROM;
          end else if (off == brg_pkg::PORT_DATA_RD) begin
            fetch = 1'b1;
            src   = SRC_PREFETCH;
          end else if (off == brg_pkg::PORT_ADDR_RD) begin
            write_low_next_nx = 1'b0;
            src               = SRC_BYTE;
            if (read_low_next) begin
              imm_byte         = serial_address[7:0];
              read_low_next_nx = 1'b0;
            end else begin
              imm_byte         = serial_address[15:8];
              read_low_next_nx = 1'b1;
            end
          end else if (off == brg_pkg::PORT_DATA_WR || off == brg_pkg::PORT_ADDR_WR) begin
            src = SRC_ZERO;
          end else begin
            // Bank window; the bank size divides the fixed region size.
            rom_re    = 1'b1;
            rom_raddr = brg_pkg::ROM_AW'(brg_pkg::FIXED_BYTES)
                      + (high_bank ? brg_pkg::ROM_AW'(brg_pkg::BANK_BYTES) : '0)
                      + brg_pkg::ROM_AW'(off[brg_pkg::BANK_BITS-1:0]);
            src       = SRC_ROM;
          end
        end
        brg_pkg::REQ_MEM_WRITE: begin
          if (off == brg_pkg::PORT_ADDR_WR) begin
            read_low_next_nx = 1'b0;
            if (write_low_next) begin
              // Low byte completes the address and starts a prefetch there.
              fetch_addr = {serial_address[15:8], req.write_data};
              fetch      = 1'b1;
            end else begin
              serial_address_next = {req.write_data, serial_address[7:0]};
              write_low_next_nx   = 1'b1;
            end
          end
        end
        brg_pkg::REQ_CTRL_BIT: begin
          if (req.address == brg_pkg::BANK_BIT_NUM) begin
            high_bank_next = req.write_data[0];
          end
        end
        brg_pkg::REQ_LOAD_ROM: begin
          rom_we = (req.address < 16'(brg_pkg::ROM_DEPTH));
        end
        brg_pkg::REQ_LOAD_SROM: begin
          srom_we = 1'b1;
        end
        default: begin
        end
      endcase
      if (fetch) begin
        srom_re             = 1'b1;
        serial_address_next = brg_pkg::wrap_inc(fetch_addr);
        read_low_next_nx    = 1'b0;
        write_low_next_nx   = 1'b0;
      end
    end
  end

  assign srom_raddr = fetch_addr[brg_pkg::SROM_AW-1:0];

  // ROM: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom[req.address[brg_pkg::ROM_AW-1:0]] <= req.write_data;
    end
    if (rom_re) begin
      rom_rdata <= rom[rom_raddr];
    end
  end

  // Serial ROM: one write port for loads, one registered read port for prefetch.
  always_ff @(posedge clk) begin
    if (srom_we) begin
      srom[req.address[brg_pkg::SROM_AW-1:0]] <= req.write_data;
    end
    if (srom_re) begin
      srom_rdata <= srom[srom_raddr];
    end
  end

  always_comb begin
    unique case (s1_src)
      SRC_ZERO:     s1_result = '0;
      SRC_ROM:      s1_result = rom_rdata;
      SRC_PREFETCH: s1_result = prefetch_byte;
      SRC_BYTE:     s1_result = s1_byte;
      default:      s1_result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_address <= '0;
      prefetch_byte  <= '0;
      read_low_next  <= 1'b0;
      write_low_next <= 1'b0;
      high_bank      <= 1'b0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      serial_address <= serial_address_next;
      read_low_next  <= read_low_next_nx;
      write_low_next <= write_low_next_nx;
      high_bank      <= high_bank_next;
      if (s1_adv && s1_fetch) begin
        prefetch_byte <= srom_rdata;
      end
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_src   <= src;
      s1_fetch <= fetch;
      s1_byte  <= imm_byte;
    end
    if (s1_adv) begin
      out_data <= s1_result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  // A prefetch always leaves both byte flip-flops cleared.
  a_fetch_clears_flops: assert property (@(posedge clk) disable iff (rst)
    acc && fetch |=> !read_low_next && !write_low_next)
    else $error("byte flip-flops not cleared by prefetch");

  // A read stage waiting on the output must block new requests.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !rsp.ready |-> !acc)
    else $error("request taken while read stage is stalled");

  // A read stage holding a fetch keeps its memory data until it moves on.
  a_rdata_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(srom_rdata) && $stable(rom_rdata))
    else $error("read data lost during stall");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for banked_rom_and_grom_port_unit: directed and random bus requests,
// with every response compared against a scoreboard that predicts the unit.
// Depends on brg_pkg, the channel interfaces in brg_if.sv and the unit itself.

class rom_port_scoreboard;
  bit [7:0]  rom_img     [brg_pkg::ROM_DEPTH];
  bit        rom_loaded  [brg_pkg::ROM_DEPTH];
  bit [7:0]  srom_img    [brg_pkg::SROM_DEPTH];
  bit        srom_loaded [brg_pkg::SROM_DEPTH];
  bit [15:0] serial_addr;
  bit [7:0]  prefetch;
  bit        rd_low;
  bit        wr_low;
  bit        high_bank;
  bit [7:0]  expected_read_data [$];
  int        errors;
  int        checked;
  int        serial_reads;

  function int bank_index(input brg_pkg::off_t off);
    return brg_pkg::FIXED_BYTES + (high_bank ? brg_pkg::BANK_BYTES : 0)
           + ((int'(off) - brg_pkg::FIXED_BYTES) % brg_pkg::BANK_BYTES);
  endfunction

  // Hands out the buffered byte and refills it; only the low part of the
  // address counts up, the bits above the wrap size stay put.
  function bit [7:0] next_serial_byte();
    bit [7:0]  old;
    bit [15:0] wrap_mask;
    old = prefetch;
    wrap_mask = 16'(brg_pkg::WRAP_BYTES - 1);
    prefetch = srom_img[serial_addr];
    serial_addr = ((serial_addr + 16'd1) & wrap_mask) | (serial_addr & ~wrap_mask);
    rd_low = 1'b0;
    wr_low = 1'b0;
    return old;
  endfunction

  // Tells which store entry a request would read, and whether it was never loaded.
  function bit missing_entry(input brg_pkg::req_type_t t, input brg_pkg::addr_t a,
                             input brg_pkg::byte_t d, output bit serial, output int idx);
    brg_pkg::off_t off;
    off = a[12:0];
    serial = 1'b0;
    idx = -1;
    if (t == brg_pkg::REQ_MEM_READ) begin
      if (off < brg_pkg::FIXED_LIMIT) begin
        idx = int'(off);
      end else if (off == brg_pkg::PORT_DATA_RD) begin
        serial = 1'b1;
        idx = int'(serial_addr);
      end else if (off != brg_pkg::PORT_ADDR_RD && off != brg_pkg::PORT_DATA_WR &&
                   off != brg_pkg::PORT_ADDR_WR) begin
        idx = bank_index(off);
      end
    end else if (t == brg_pkg::REQ_MEM_WRITE && off == brg_pkg::PORT_ADDR_WR && wr_low) begin
      serial = 1'b1;
      idx = int'({serial_addr[15:8], d});
    end
    if (idx < 0) return 1'b0;
    return serial ? !srom_loaded[idx] : !rom_loaded[idx];
  endfunction

  function void note_request(input brg_pkg::req_type_t t, input brg_pkg::addr_t a,
                             input brg_pkg::byte_t d);
    brg_pkg::off_t off;
    bit [7:0]      r;
    off = a[12:0];
    r = 8'h00;
    case (t)
      brg_pkg::REQ_MEM_READ: begin
        if (off < brg_pkg::FIXED_LIMIT) begin
          r = rom_img[off];
        end else if (off == brg_pkg::PORT_DATA_RD) begin
          r = next_serial_byte();
          serial_reads++;
        end else if (off == brg_pkg::PORT_ADDR_RD) begin
          wr_low = 1'b0;
          if (rd_low) begin
            r = serial_addr[7:0];
            rd_low = 1'b0;
          end else begin
            r = serial_addr[15:8];
            rd_low = 1'b1;
          end
        end else if (off != brg_pkg::PORT_DATA_WR && off != brg_pkg::PORT_ADDR_WR) begin
          r = rom_img[bank_index(off)];
        end
      end
      brg_pkg::REQ_MEM_WRITE: begin
        if (off == brg_pkg::PORT_ADDR_WR) begin
          rd_low = 1'b0;
          if (wr_low) begin
            serial_addr[7:0] = d;
            void'(next_serial_byte());
          end else begin
            serial_addr[15:8] = d;
            wr_low = 1'b1;
          end
        end
      end
      brg_pkg::REQ_CTRL_BIT: begin
        if (a == brg_pkg::BANK_BIT_NUM) high_bank = d[0];
      end
      brg_pkg::REQ_LOAD_ROM: begin
        if (int'(a) < brg_pkg::ROM_DEPTH) begin
          rom_img[a] = d;
          rom_loaded[a] = 1'b1;
        end
      end
      brg_pkg::REQ_LOAD_SROM: begin
        srom_img[a] = d;
        srom_loaded[a] = 1'b1;
      end
      default: begin
      end
    endcase
    expected_read_data.push_back(r);
  endfunction

  function void check_read_data(input brg_pkg::byte_t got);
    bit [7:0] want;
    if (expected_read_data.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected response, read_data 0x%02h", got);
      return;
    end
    want = expected_read_data.pop_front();
    checked++;
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("read_data mismatch on response %0d: expected 0x%02h, got 0x%02h",
                 checked, want, got);
    end
  endfunction
endclass

module tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle_pct = 18;
  int   sink_idle_pct = 70;
  int   issued;
  rom_port_scoreboard board;

  always #2 clk = ~clk;

  brg_req_if req_ch (.clk(clk));
  brg_rsp_if rsp_ch (.clk(clk));

  banked_rom_and_grom_port_unit u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) board.check_read_data(rsp_ch.read_data);
  end

  // Card offset with random don't-care bits above bit 12.
  function automatic brg_pkg::addr_t card_addr(input brg_pkg::off_t off);
    return {3'($urandom_range(7)), off};
  endfunction

  task automatic send_request(input brg_pkg::req_type_t t, input brg_pkg::addr_t a,
                              input brg_pkg::byte_t d);
    if ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= t;
    req_ch.address    <= a;
    req_ch.write_data <= d;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(t, a, d);
    issued++;
  endtask

  // A request that would read a never-loaded entry gets a load of that entry first.
  task automatic issue(input brg_pkg::req_type_t t, input brg_pkg::addr_t a,
                       input brg_pkg::byte_t d);
    bit serial;
    int idx;
    if (board.missing_entry(t, a, d, serial, idx)) begin
      if (serial) send_request(brg_pkg::REQ_LOAD_SROM, 16'(idx), 8'($urandom));
      else send_request(brg_pkg::REQ_LOAD_ROM, 16'(idx), 8'($urandom));
    end
    send_request(t, a, d);
  endtask

  task automatic run_random(input int target);
    int                 start;
    int                 done;
    int                 kind;
    bit [15:0]          sa;
    brg_pkg::req_type_t t;
    brg_pkg::addr_t     a;
    start = issued;
    while (issued - start < target) begin
      done = issued - start;
      if (done < target / 3) begin
        src_idle_pct = 18;
        sink_idle_pct = 70;
      end else if (done < 2 * target / 3) begin
        src_idle_pct = 70;
        sink_idle_pct = 18;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      kind = $urandom_range(99);
      if (kind < 20) begin
        if ($urandom_range(1)) a = card_addr(13'($urandom_range(12'hFFF)));
        else a = card_addr(13'($urandom_range(13'h1FFF, 13'h1000)));
        issue(brg_pkg::REQ_MEM_READ, a, 8'($urandom));
      end else if (kind < 30) begin
        if ($urandom_range(1)) issue(brg_pkg::REQ_LOAD_ROM, 16'($urandom_range(16'h3FFF)),
                                     8'($urandom));
        else issue(brg_pkg::REQ_LOAD_SROM, 16'($urandom), 8'($urandom));
      end else if (kind < 40) begin
        a = ($urandom_range(9) < 8) ? brg_pkg::BANK_BIT_NUM : 16'($urandom);
        issue(brg_pkg::REQ_CTRL_BIT, a, 8'($urandom));
      end else if (kind < 75) begin
        // Set the serial address, often just below the wrap point, then stream it.
        if ($urandom_range(9) < 3) sa = {3'($urandom_range(7)), 13'(13'h1FF8 + $urandom_range(7))};
        else sa = 16'($urandom);
        issue(brg_pkg::REQ_MEM_WRITE, card_addr(brg_pkg::PORT_ADDR_WR), sa[15:8]);
        issue(brg_pkg::REQ_MEM_WRITE, card_addr(brg_pkg::PORT_ADDR_WR), sa[7:0]);
        repeat ($urandom_range(10, 1))
          issue(brg_pkg::REQ_MEM_READ, card_addr(brg_pkg::PORT_DATA_RD), 8'($urandom));
        if ($urandom_range(9) < 3)
          repeat (2) issue(brg_pkg::REQ_MEM_READ, card_addr(brg_pkg::PORT_ADDR_RD), 8'($urandom));
      end else if (kind < 85) begin
        repeat ($urandom_range(3, 1))
          issue(brg_pkg::REQ_MEM_READ, card_addr(brg_pkg::PORT_ADDR_RD), 8'($urandom));
      end else begin
        // Noise: any request kind, often aimed at the serial ports or their odd neighbors.
        t = 3'($urandom);
        a = 16'($urandom);
        if ($urandom_range(1))
          a[12:0] = ($urandom_range(1) ? brg_pkg::PORT_DATA_RD : brg_pkg::PORT_DATA_WR)
                    + 13'($urandom_range(3));
        issue(t, a, 8'($urandom));
      end
    end
  endtask

  initial begin
    board = new;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= brg_pkg::REQ_MEM_READ;
    req_ch.address    <= '0;
    req_ch.write_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: store extremes, both banks, odd port offsets, ignored requests,
    // serial address wrap and the byte flip-flops.
    issue(brg_pkg::REQ_LOAD_ROM, 16'h0000, 8'h00);
    issue(brg_pkg::REQ_LOAD_ROM, 16'h2FFF, 8'hFF);
    issue(brg_pkg::REQ_LOAD_ROM, 16'h3000, 8'hA5);
    issue(brg_pkg::REQ_LOAD_ROM, 16'hFFFF, 8'h5A);
    issue(brg_pkg::REQ_MEM_READ, 16'hE000, 8'h00);
    issue(brg_pkg::REQ_MEM_READ, 16'h1000, 8'hFF);
    issue(brg_pkg::REQ_CTRL_BIT, brg_pkg::BANK_BIT_NUM, 8'h01);
    issue(brg_pkg::REQ_MEM_READ, 16'h1FFF, 8'hFF);
    issue(brg_pkg::REQ_CTRL_BIT, 16'h0041, 8'h00);
    issue(brg_pkg::REQ_MEM_READ, 16'h1BFD, 8'h00);
    issue(brg_pkg::REQ_CTRL_BIT, brg_pkg::BANK_BIT_NUM, 8'hFE);
    issue(brg_pkg::REQ_MEM_READ, {3'b000, brg_pkg::PORT_DATA_WR}, 8'h00);
    issue(brg_pkg::REQ_MEM_READ, {3'b111, brg_pkg::PORT_ADDR_WR}, 8'h00);
    issue(brg_pkg::REQ_MEM_WRITE, {3'b000, brg_pkg::PORT_DATA_WR}, 8'h77);
    issue(brg_pkg::REQ_MEM_WRITE, 16'h0123, 8'h55);
    issue(brg_pkg::REQ_LOAD_SROM, 16'hFFFF, 8'hC3);
    issue(brg_pkg::REQ_MEM_WRITE, {3'b111, brg_pkg::PORT_ADDR_WR}, 8'hFF);
    issue(brg_pkg::REQ_MEM_WRITE, {3'b000, brg_pkg::PORT_ADDR_WR}, 8'hFF);
    issue(brg_pkg::REQ_MEM_READ, {3'b000, brg_pkg::PORT_DATA_RD}, 8'h00);
    issue(brg_pkg::REQ_MEM_READ, {3'b000, brg_pkg::PORT_ADDR_RD}, 8'h00);
    issue(brg_pkg::REQ_MEM_READ, {3'b101, brg_pkg::PORT_ADDR_RD}, 8'h00);
    issue(brg_pkg::REQ_MEM_WRITE, {3'b000, brg_pkg::PORT_ADDR_WR}, 8'h12);
    issue(brg_pkg::REQ_MEM_READ, {3'b000, brg_pkg::PORT_ADDR_RD}, 8'h00);
    issue(brg_pkg::REQ_MEM_WRITE, {3'b000, brg_pkg::PORT_ADDR_WR}, 8'h34);
    issue(3'd5, 16'hFFFF, 8'hFF);
    issue(3'd6, 16'h0040, 8'h01);
    issue(3'd7, 16'h1BFC, 8'h00);

    run_random(1200);
    req_ch.valid <= 1'b0;

    while (board.expected_read_data.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (board.expected_read_data.size() != 0)
      $display("%0d responses never arrived", board.expected_read_data.size());
    $display("Sent %0d requests and checked %0d responses, %0d of them serial data reads.",
             issued, board.checked, board.serial_reads);
    $display("Covered both ROM banks, serial address wrap, the port flip-flops and idle mixes.");
    if (board.errors == 0 && board.expected_read_data.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("run timed out");
    $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/brg_pkg.sv
hdl/brg_if.sv
hdl/banked_rom_and_grom_port_unit.sv
test/tb.sv
